// File: sv/mmq_pkg.sv
// types, constants and microcode for the midi message transmit queue
// no dependencies

package mmq_pkg;

	localparam int OP_W    = 4;
	localparam int CHAN_W  = 5;
	localparam int NUM_W   = 8;
	localparam int VAL_W   = 14;
	localparam int BYTE_W  = 8;
	localparam int CNTR_W  = 3;
	localparam int FILL_W  = 7;
	localparam int NIB_W   = 4;
	localparam int STEP_W  = 5;

	localparam logic [OP_W-1:0] OP_NOTE_ON    = 4'd0;
	localparam logic [OP_W-1:0] OP_NOTE_OFF   = 4'd1;
	localparam logic [OP_W-1:0] OP_AFTERTOUCH = 4'd2;
	localparam logic [OP_W-1:0] OP_BEND       = 4'd3;
	localparam logic [OP_W-1:0] OP_CONTROL    = 4'd4;
	localparam logic [OP_W-1:0] OP_PROGRAM    = 4'd5;
	localparam logic [OP_W-1:0] OP_RX_MODE    = 4'd6;
	localparam logic [OP_W-1:0] OP_SOUND_OFF  = 4'd7;
	localparam logic [OP_W-1:0] OP_RESET_CTRL = 4'd8;
	localparam logic [OP_W-1:0] OP_TICK       = 4'd9;

	localparam logic [BYTE_W-1:0] MSG_NOTE_ON    = 8'h90;
	localparam logic [BYTE_W-1:0] MSG_NOTE_OFF   = 8'h80;
	localparam logic [BYTE_W-1:0] MSG_AFTERTOUCH = 8'hD0;
	localparam logic [BYTE_W-1:0] MSG_BEND       = 8'hE0;
	localparam logic [BYTE_W-1:0] MSG_CONTROL    = 8'hB0;
	localparam logic [BYTE_W-1:0] MSG_PROGRAM    = 8'hC0;
	localparam logic [BYTE_W-1:0] DATA_MASK      = 8'h7F;

	localparam logic [BYTE_W-1:0] CC_SOUND_OFF  = 8'd120;
	localparam logic [BYTE_W-1:0] CC_RESET_CTRL = 8'd121;
	localparam logic [BYTE_W-1:0] CC_OMNI_OFF   = 8'd124;
	localparam logic [BYTE_W-1:0] CC_OMNI_ON    = 8'd125;
	localparam logic [BYTE_W-1:0] CC_MONO       = 8'd126;
	localparam logic [BYTE_W-1:0] CC_POLY       = 8'd127;
	localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'd0;
	localparam logic [BYTE_W-1:0] BYTE_ONE      = 8'd1;

	localparam logic [NUM_W-1:0] RX_MODE_1 = 8'd1;
	localparam logic [NUM_W-1:0] RX_MODE_2 = 8'd2;
	localparam logic [NUM_W-1:0] RX_MODE_3 = 8'd3;

	// program entry points and jump targets
	localparam logic [STEP_W-1:0] STEP_NOTE_ON    = 5'd0;
	localparam logic [STEP_W-1:0] STEP_NOTE_OFF   = 5'd3;
	localparam logic [STEP_W-1:0] STEP_ZERO_FIN   = 5'd5;
	localparam logic [STEP_W-1:0] STEP_AFTERTOUCH = 5'd6;
	localparam logic [STEP_W-1:0] STEP_BEND       = 5'd8;
	localparam logic [STEP_W-1:0] STEP_CONTROL    = 5'd11;
	localparam logic [STEP_W-1:0] STEP_PROGRAM    = 5'd14;
	localparam logic [STEP_W-1:0] STEP_RX_MODE    = 5'd16;
	localparam logic [STEP_W-1:0] STEP_RX_OMNI_ON = 5'd18;
	localparam logic [STEP_W-1:0] STEP_RX_ZERO    = 5'd19;
	localparam logic [STEP_W-1:0] STEP_RX_POLY    = 5'd23;
	localparam logic [STEP_W-1:0] STEP_SOUND_OFF  = 5'd25;
	localparam logic [STEP_W-1:0] STEP_RESET_CTRL = 5'd27;
	localparam logic [STEP_W-1:0] STEP_TICK       = 5'd29;
	localparam logic [STEP_W-1:0] STEP_NOP        = 5'd31;
	localparam logic [STEP_W-1:0] STEP_NONE       = 5'd0;

	typedef enum logic [1:0] {
		UOP_NOP  = 2'd0,
		UOP_PUSH = 2'd1,
		UOP_POP  = 2'd2,
		UOP_TAKE = 2'd3
	} uop_t;

	typedef enum logic [2:0] {
		SRC_STATUS = 3'd0,
		SRC_NUM    = 3'd1,
		SRC_VAL_LO = 3'd2,
		SRC_VAL_HI = 3'd3,
		SRC_CONST  = 3'd4
	} src_t;

	typedef enum logic [1:0] {
		COND_NONE   = 2'd0,
		COND_ALWAYS = 2'd1,
		COND_OMNI   = 2'd2,
		COND_POLY   = 2'd3
	} cond_t;

	typedef struct packed {
		uop_t              uop;
		src_t              src;
		logic [BYTE_W-1:0] imm;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              fin;
	} ucode_t;

	typedef struct packed {
		logic   idle;
		logic   exec;
		logic   load;
		ucode_t uw;
	} seq_ctrl_t;

	function automatic ucode_t ucode(input logic [STEP_W-1:0] addr);
		ucode_t u;
		case (addr)
			5'd0:  u = '{UOP_PUSH, SRC_STATUS, MSG_NOTE_ON, COND_NONE, STEP_NONE, 1'b0};
			5'd1:  u = '{UOP_PUSH, SRC_NUM, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b0};
			5'd2:  u = '{UOP_PUSH, SRC_VAL_LO, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
			5'd3:  u = '{UOP_PUSH, SRC_STATUS, MSG_NOTE_OFF, COND_NONE, STEP_NONE, 1'b0};
			5'd4:  u = '{UOP_PUSH, SRC_NUM, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b0};
			5'd5:  u = '{UOP_PUSH, SRC_CONST, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
			5'd6:  u = '{UOP_PUSH, SRC_STATUS, MSG_AFTERTOUCH, COND_NONE, STEP_NONE, 1'b0};
			5'd7:  u = '{UOP_PUSH, SRC_NUM, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
			5'd8:  u = '{UOP_PUSH, SRC_STATUS, MSG_BEND, COND_NONE, STEP_NONE, 1'b0};
			5'd9:  u = '{UOP_PUSH, SRC_VAL_LO, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b0};
			5'd10: u = '{UOP_PUSH, SRC_VAL_HI, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
			5'd11: u = '{UOP_PUSH, SRC_STATUS, MSG_CONTROL, COND_NONE, STEP_NONE, 1'b0};
			5'd12: u = '{UOP_PUSH, SRC_NUM, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b0};
			5'd13: u = '{UOP_PUSH, SRC_VAL_LO, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
			5'd14: u = '{UOP_PUSH, SRC_STATUS, MSG_PROGRAM, COND_NONE, STEP_NONE, 1'b0};
			5'd15: u = '{UOP_PUSH, SRC_NUM, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
			5'd16: u = '{UOP_PUSH, SRC_STATUS, MSG_CONTROL, COND_OMNI, STEP_RX_OMNI_ON, 1'b0};
			5'd17: u = '{UOP_PUSH, SRC_CONST, CC_OMNI_OFF, COND_ALWAYS, STEP_RX_ZERO, 1'b0};
			5'd18: u = '{UOP_PUSH, SRC_CONST, CC_OMNI_ON, COND_NONE, STEP_NONE, 1'b0};
			5'd19: u = '{UOP_PUSH, SRC_CONST, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b0};
			5'd20: u = '{UOP_PUSH, SRC_STATUS, MSG_CONTROL, COND_POLY, STEP_RX_POLY, 1'b0};
			5'd21: u = '{UOP_PUSH, SRC_CONST, CC_MONO, COND_NONE, STEP_NONE, 1'b0};
			5'd22: u = '{UOP_PUSH, SRC_CONST, BYTE_ONE, COND_NONE, STEP_NONE, 1'b1};
			5'd23: u = '{UOP_PUSH, SRC_CONST, CC_POLY, COND_NONE, STEP_NONE, 1'b0};
			5'd24: u = '{UOP_PUSH, SRC_CONST, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
			5'd25: u = '{UOP_PUSH, SRC_STATUS, MSG_CONTROL, COND_NONE, STEP_NONE, 1'b0};
			5'd26: u = '{UOP_PUSH, SRC_CONST, CC_SOUND_OFF, COND_ALWAYS, STEP_ZERO_FIN, 1'b0};
			5'd27: u = '{UOP_PUSH, SRC_STATUS, MSG_CONTROL, COND_NONE, STEP_NONE, 1'b0};
			5'd28: u = '{UOP_PUSH, SRC_CONST, CC_RESET_CTRL, COND_ALWAYS, STEP_ZERO_FIN, 1'b0};
			5'd29: u = '{UOP_POP, SRC_CONST, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b0};
			5'd30: u = '{UOP_TAKE, SRC_CONST, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
			default: u = '{UOP_NOP, SRC_CONST, BYTE_ZERO, COND_NONE, STEP_NONE, 1'b1};
		endcase
		return u;
	endfunction

	function automatic logic [STEP_W-1:0] entry_step(input logic [OP_W-1:0] op);
		logic [STEP_W-1:0] s;
		case (op)
			OP_NOTE_ON:    s = STEP_NOTE_ON;
			OP_NOTE_OFF:   s = STEP_NOTE_OFF;
			OP_AFTERTOUCH: s = STEP_AFTERTOUCH;
			OP_BEND:       s = STEP_BEND;
			OP_CONTROL:    s = STEP_CONTROL;
			OP_PROGRAM:    s = STEP_PROGRAM;
			OP_RX_MODE:    s = STEP_RX_MODE;
			OP_SOUND_OFF:  s = STEP_SOUND_OFF;
			OP_RESET_CTRL: s = STEP_RESET_CTRL;
			OP_TICK:       s = STEP_TICK;
			default:       s = STEP_NOP;
		endcase
		return s;
	endfunction

endpackage

// File: sv/mmq_if.sv
// request and response channel interfaces of the midi message transmit queue
// depends on mmq_pkg

interface mmq_req_if import mmq_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [CHAN_W-1:0] channel;
	logic [NUM_W-1:0]  number;
	logic [VAL_W-1:0]  data_value;
	logic              line_ready;

	modport source (output valid, op, channel, number, data_value, line_ready, input ready);
	modport sink (input valid, op, channel, number, data_value, line_ready, output ready);
endinterface

interface mmq_rsp_if import mmq_pkg::*;;
	logic              valid;
	logic              ready;
	logic              tx_valid;
	logic [BYTE_W-1:0] tx_byte;
	logic [CNTR_W-1:0] bytes_queued;
	logic [CNTR_W-1:0] bytes_dropped;
	logic [FILL_W-1:0] fill_level;

	modport source (output valid, tx_valid, tx_byte, bytes_queued, bytes_dropped, fill_level,
		input ready);
	modport sink (input valid, tx_valid, tx_byte, bytes_queued, bytes_dropped, fill_level,
		output ready);
endinterface

// File: sv/mmq_ram.sv
// generic single-port ram with registered read
// no dependencies

module mmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: sv/mmq_seq.sv
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on mmq_pkg

module mmq_seq import mmq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] op,
	input  logic            omni,
	input  logic            poly,
	input  logic            out_free,
	output seq_ctrl_t       ctrl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_POST = 3'b100
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	ucode_t            uw;
	logic              jump;

	assign uw = ucode(step_q);

	always_comb begin
		case (uw.cond)
			COND_ALWAYS: jump = 1'b1;
			COND_OMNI:   jump = omni;
			COND_POLY:   jump = poly;
			default:     jump = 1'b0;
		endcase
	end

	assign ctrl.idle = (state_q == ST_IDLE);
	assign ctrl.exec = (state_q == ST_RUN);
	assign ctrl.load = (state_q == ST_POST) && out_free;
	assign ctrl.uw   = uw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_NOP;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						step_q  <= entry_step(op);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (uw.fin) begin
						state_q <= ST_POST;
					end else if (jump) begin
						step_q <= uw.target;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_POST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && start |=> (state_q == ST_RUN))
		else $error("sequencer did not start on accepted transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && uw.fin |=> (state_q == ST_POST))
		else $error("sequencer missed end of program");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && !uw.fin && (uw.cond == COND_ALWAYS) |=> (step_q == $past(uw.target)))
		else $error("unconditional jump not taken");

endmodule

// File: sv/midi_message_tx_queue.sv
// midi channel message encoder with a byte transmit queue, top level
// depends on mmq_pkg, mmq_if, mmq_ram and mmq_seq
//
// usage:
// req carries one transaction per request: a channel message (note on/off,
// aftertouch, bend, control, program, receiver mode, sound off, reset
// controllers) or a tick. a message is split into its bytes and each byte is
// pushed into the queue; a byte that finds the queue full is dropped. a tick
// with line_ready pops one byte when the queue is not empty.
// rsp returns exactly one transaction per request with the popped byte, the
// bytes queued and dropped for this request and the fill level afterwards.
// timing: one request at a time; a request runs one microcode step per
// queue byte (two steps for a tick, one for an unused opcode), then loads
// the response register. the response becomes valid and req is ready again
// at the same edge. the single ram port does one push or pop a cycle.
// reset empties the queue; the ram contents are not cleared.
// a stalled rsp holds its response; the next request may be accepted and run
// meanwhile, and waits at its end until the response register is free.

module midi_message_tx_queue import mmq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	mmq_req_if.sink   req,
	mmq_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	seq_ctrl_t         ctrl;
	logic              start;
	logic              out_free;
	logic              omni;
	logic              poly;

	logic [NIB_W-1:0]  chan_q;
	logic [NUM_W-1:0]  num_q;
	logic [VAL_W-1:0]  val_q;
	logic              line_ready_q;

	logic [IDX_W-1:0]  wr_idx_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNTR_W-1:0] queued_q;
	logic [CNTR_W-1:0] dropped_q;
	logic              pop_q;
	logic [BYTE_W-1:0] byte_q;

	logic              out_valid_q;
	logic              out_tx_valid_q;
	logic [BYTE_W-1:0] out_tx_byte_q;
	logic [CNTR_W-1:0] out_queued_q;
	logic [CNTR_W-1:0] out_dropped_q;
	logic [FILL_W-1:0] out_fill_q;

	logic [BYTE_W-1:0] push_byte;
	logic              do_push;
	logic              do_pop;
	logic              has_room;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_addr;
	logic [BYTE_W-1:0] ram_rdata;

	assign start    = req.valid && req.ready;
	assign req.ready = ctrl.idle;
	assign out_free = !out_valid_q || rsp.ready;

	assign omni = (num_q == RX_MODE_1) || (num_q == RX_MODE_2);
	assign poly = (num_q == RX_MODE_1) || (num_q == RX_MODE_3);

	mmq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (req.op),
		.omni     (omni),
		.poly     (poly),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	always_comb begin
		case (ctrl.uw.src)
			SRC_STATUS: push_byte = ctrl.uw.imm | {{(BYTE_W-NIB_W){1'b0}}, chan_q};
			SRC_NUM:    push_byte = num_q & DATA_MASK;
			SRC_VAL_LO: push_byte = BYTE_W'(val_q) & DATA_MASK;
			SRC_VAL_HI: push_byte = BYTE_W'(val_q >> 7) & DATA_MASK;
			default:    push_byte = ctrl.uw.imm;
		endcase
	end

	assign has_room = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign do_push  = ctrl.exec && (ctrl.uw.uop == UOP_PUSH);
	assign do_pop   = ctrl.exec && (ctrl.uw.uop == UOP_POP) && (cnt_q != '0) && line_ready_q;
	assign ram_we   = do_push && has_room;
	assign ram_addr = do_push ? wr_idx_q : rd_idx_q;

	mmq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (push_byte),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (start) begin
			chan_q       <= NIB_W'(req.channel - CHAN_W'(1));
			num_q        <= req.number;
			val_q        <= req.data_value;
			line_ready_q <= req.line_ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			cnt_q     <= '0;
			queued_q  <= '0;
			dropped_q <= '0;
			pop_q     <= 1'b0;
			byte_q    <= '0;
		end else begin
			if (start) begin
				queued_q  <= '0;
				dropped_q <= '0;
				pop_q     <= 1'b0;
				byte_q    <= '0;
			end
			if (do_push) begin
				if (has_room) begin
					wr_idx_q <= (wr_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_q + IDX_W'(1);
					cnt_q    <= cnt_q + CNT_W'(1);
					queued_q <= queued_q + CNTR_W'(1);
				end else begin
					dropped_q <= dropped_q + CNTR_W'(1);
				end
			end
			if (do_pop) begin
				rd_idx_q <= (rd_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_q + IDX_W'(1);
				cnt_q    <= cnt_q - CNT_W'(1);
				pop_q    <= 1'b1;
			end
			if (ctrl.exec && (ctrl.uw.uop == UOP_TAKE) && pop_q) begin
				byte_q <= ram_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			out_tx_valid_q <= pop_q;
			out_tx_byte_q  <= byte_q;
			out_queued_q   <= queued_q;
			out_dropped_q  <= dropped_q;
			out_fill_q     <= FILL_W'(cnt_q);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.tx_valid      = out_tx_valid_q;
	assign rsp.tx_byte       = out_tx_byte_q;
	assign rsp.bytes_queued  = out_queued_q;
	assign rsp.bytes_dropped = out_dropped_q;
	assign rsp.fill_level    = out_fill_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !do_pop)
		else $error("push and pop in the same cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !req.ready)
		else $error("second transaction accepted while one runs");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.tx_valid |-> (rsp.bytes_queued == '0) && (rsp.bytes_dropped == '0))
		else $error("pop reported together with pushes");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> ({1'b0, queued_q} + {1'b0, dropped_q}) <= (CNTR_W+1)'(6))
		else $error("more than six bytes counted for one request");

endmodule
